// ===== rtl/qvr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants, tables and types of the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // default width of every input and output component
    localparam int DATA_WIDTH_DEF = 32;

    // unit quaternion format Q2.30
    localparam int UNIT_BITS = 30;
    localparam int UW        = UNIT_BITS + 2;
    localparam logic signed [UW-1:0] UNIT_ONE = UW'(1) << UNIT_BITS;

    // normalizer datapath widths
    localparam int SQ_W       = 2 * UNIT_BITS;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_STEPS = SUM_W / 2 + 1;
    localparam int ROOT_W     = 64;
    localparam int QUO_W      = UNIT_BITS + 1;
    localparam int DIVR_W     = SUM_W;

    // latencies
    localparam int NORM_LAT = 5 + ROOT_STEPS + 1 + QUO_W + 1;
    localparam int MUL_LAT  = 3;
    localparam int ROT_LAT  = 2 * MUL_LAT + 3;

    // operand selection of the two product layers
    localparam int L1_N = 6;
    localparam int L1_U [L1_N] = '{1, 2, 2, 0, 0, 1};
    localparam int L1_V [L1_N] = '{2, 1, 0, 2, 1, 0};
    localparam int L2_N = 9;
    localparam int L2_U [L2_N] = '{3, 1, 2, 3, 2, 0, 3, 0, 1};
    localparam int L2_T [L2_N] = '{0, 2, 1, 1, 0, 2, 2, 1, 0};

    // control that travels beside the data between pipeline sections
    typedef struct packed {
        logic valid;
        logic ident;
    } qvr_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/qvr_sample_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_sample_if
// Input channel: one quaternion and one vector per item.
// ----------------------------------------------------------------------------
interface qvr_sample_if #(
    parameter int DW = qvr_pkg::DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] vec_x;
    logic signed [DW-1:0] vec_y;
    logic signed [DW-1:0] vec_z;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/qvr_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_result_if
// Output channel: one rotated vector and its flags per item.
// ----------------------------------------------------------------------------
interface qvr_result_if #(
    parameter int DW = qvr_pkg::DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] rot_x;
    logic signed [DW-1:0] rot_y;
    logic signed [DW-1:0] rot_z;
    logic                 identity_used;
    logic                 clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, identity_used, clipped,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, identity_used, clipped,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/qvr_norm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_norm
// Quaternion normalizer: block scaling, sum of squares, pipelined square
// root (one result bit per stage) and four pipelined restoring dividers.
// ----------------------------------------------------------------------------
module qvr_norm #(
    parameter int DW = qvr_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [DW-1:0]        quat [4],
    input  logic signed [DW-1:0]        vec [3],
    output logic signed [qvr_pkg::UW-1:0] unit [4],
    output logic signed [DW-1:0]        vec_out [3],
    output qvr_pkg::qvr_ctrl_t          ctrl
);
    import qvr_pkg::*;

    localparam int SW   = 3 * DW + 5;
    localparam int TOPW = $clog2(DW);
    localparam int WW   = DW + UNIT_BITS;

    // sideband: vector, component signs, identity flag
    logic [SW-1:0] side_in;
    logic [SW-1:0] side_reg  [NORM_LAT];
    logic          valid_reg [NORM_LAT];

    // datapath stages
    logic [DW-1:0]        mag_reg  [4];
    logic [DW-1:0]        mag1_reg [4];
    logic [TOPW-1:0]      top_reg;
    logic [DW-1:0]        m_or;
    logic [TOPW-1:0]      top_next;
    logic [UNIT_BITS-1:0] sh_next  [4];
    logic [UNIT_BITS-1:0] sh_reg   [4];
    logic [SQ_W-1:0]      sq_reg   [4];
    logic [SUM_W-1:0]     sum_reg;
    logic [UNIT_BITS-1:0] a_reg    [ROOT_STEPS+2][4];
    logic [ROOT_W-1:0]    rt_rem_in   [ROOT_STEPS];
    logic [ROOT_W-1:0]    rt_root_in  [ROOT_STEPS];
    logic [ROOT_W-1:0]    rt_rem_reg  [ROOT_STEPS];
    logic [ROOT_W-1:0]    rt_root_reg [ROOT_STEPS];
    logic [DIVR_W-1:0]    dv_rem_reg  [QUO_W+1][4];
    logic [QUO_W-1:0]     dv_q_reg    [QUO_W+1][4];
    logic [QUO_W-1:0]     dv_n_reg    [QUO_W+1];
    logic signed [UW-1:0] unit_reg [4];

    assign side_in = {vec[2], vec[1], vec[0],
                      quat[3][DW-1], quat[2][DW-1], quat[1][DW-1], quat[0][DW-1],
                      (quat[0] == '0) && (quat[1] == '0) &&
                      (quat[2] == '0) && (quat[3] == '0)};

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORM_LAT; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < NORM_LAT; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // advance sideband
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NORM_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // find leading one of the OR of magnitudes
    always_comb
    begin
        m_or     = mag_reg[0] | mag_reg[1] | mag_reg[2] | mag_reg[3];
        top_next = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (m_or[i])
            begin
                top_next = TOPW'(i);
            end
        end
    end

    // scale so the leading one sits on bit 29
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (int'(top_reg) > UNIT_BITS - 1)
            begin
                sh_next[i] = UNIT_BITS'(WW'(mag1_reg[i]) >> (int'(top_reg) - (UNIT_BITS - 1)));
            end
            else
            begin
                sh_next[i] = UNIT_BITS'(WW'(mag1_reg[i]) << ((UNIT_BITS - 1) - int'(top_reg)));
            end
        end
    end

    // magnitude, leading one, scale, square, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i]  <= quat[i][DW-1] ? DW'(-quat[i]) : DW'(quat[i]);
                mag1_reg[i] <= mag_reg[i];
                sh_reg[i]   <= sh_next[i];
                sq_reg[i]   <= SQ_W'(sh_reg[i]) * SQ_W'(sh_reg[i]);
                a_reg[0][i] <= sh_reg[i];
                for (int k = 1; k < ROOT_STEPS + 2; k++)
                begin
                    a_reg[k][i] <= a_reg[k-1][i];
                end
            end
            top_reg <= top_next;
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) +
                       SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        end
    end

    // square root, one result bit per stage
    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++)
        begin : g_root
            localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
            logic [ROOT_W-1:0] trial;

            if (k == 0)
            begin : g_first
                assign rt_rem_in[k]  = ROOT_W'(sum_reg);
                assign rt_root_in[k] = '0;
            end
            else
            begin : g_next
                assign rt_rem_in[k]  = rt_rem_reg[k-1];
                assign rt_root_in[k] = rt_root_reg[k-1];
            end

            assign trial = rt_root_in[k] + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rt_rem_in[k] >= trial)
                    begin
                        rt_rem_reg[k]  <= rt_rem_in[k] - trial;
                        rt_root_reg[k] <= (rt_root_in[k] >> 1) + BIT;
                    end
                    else
                    begin
                        rt_rem_reg[k]  <= rt_rem_in[k];
                        rt_root_reg[k] <= rt_root_in[k] >> 1;
                    end
                end
            end
        end
    endgenerate

    // form rounded dividends
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[0][i] <= (DIVR_W'(a_reg[ROOT_STEPS+1][i]) << UNIT_BITS) +
                                    DIVR_W'(rt_root_reg[ROOT_STEPS-1][QUO_W-1:1]);
                dv_q_reg[0][i]   <= '0;
            end
            dv_n_reg[0] <= rt_root_reg[ROOT_STEPS-1][QUO_W-1:0];
        end
    end

    // restoring division, one quotient bit per stage
    genvar j;
    generate
        for (j = 0; j < QUO_W; j++)
        begin : g_div
            localparam int QB = QUO_W - 1 - j;
            logic [DIVR_W-1:0] nsh;

            assign nsh = DIVR_W'(dv_n_reg[j]) << QB;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (dv_rem_reg[j][i] >= nsh)
                        begin
                            dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - nsh;
                            dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | (QUO_W'(1) << QB);
                        end
                        else
                        begin
                            dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                            dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                        end
                    end
                    dv_n_reg[j+1] <= dv_n_reg[j];
                end
            end
        end
    endgenerate

    // apply signs, substitute identity for a zero quaternion
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (side_reg[NORM_LAT-2][0])
                begin
                    unit_reg[i] <= (i == 3) ? UNIT_ONE : '0;
                end
                else if (side_reg[NORM_LAT-2][1+i])
                begin
                    unit_reg[i] <= -signed'(UW'(dv_q_reg[QUO_W][i]));
                end
                else
                begin
                    unit_reg[i] <= signed'(UW'(dv_q_reg[QUO_W][i]));
                end
            end
        end
    end

    assign unit       = unit_reg;
    assign vec_out[0] = side_reg[NORM_LAT-1][5 +: DW];
    assign vec_out[1] = side_reg[NORM_LAT-1][5 + DW +: DW];
    assign vec_out[2] = side_reg[NORM_LAT-1][5 + 2 * DW +: DW];
    assign ctrl.valid = valid_reg[NORM_LAT-1];
    assign ctrl.ident = side_reg[NORM_LAT-1][0];

endmodule
`default_nettype wire

// ===== rtl/qvr_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_mul
// Unit-quaternion component times a signed value, scaled back by 2^30 and
// rounded half away from zero. Three stages, two partial products.
// ----------------------------------------------------------------------------
module qvr_mul #(
    parameter int BW = qvr_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [qvr_pkg::UW-1:0] a,
    input  logic signed [BW-1:0]          b,
    output logic signed [BW:0]            p
);
    import qvr_pkg::*;

    localparam int AW = UNIT_BITS + 1;
    localparam int LO = BW / 2;
    localparam int HI = BW - LO;
    localparam int PW = AW + BW + 1;

    logic [AW-1:0]      ua_reg;
    logic [BW-1:0]      ub_reg;
    logic               neg1_reg;
    logic [AW+LO-1:0]   plo_reg;
    logic [AW+HI-1:0]   phi_reg;
    logic               neg2_reg;
    logic [PW-1:0]      sum;
    logic [BW-1:0]      mag;
    logic signed [BW:0] p_reg;

    // round and scale back
    assign sum = (PW'(phi_reg) << LO) + PW'(plo_reg) + (PW'(1) << (UNIT_BITS - 1));
    assign mag = sum[UNIT_BITS +: BW];

    // split magnitudes, multiply halves, combine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= a[UW-1] ? AW'(-a) : AW'(a);
            ub_reg   <= b[BW-1] ? BW'(-b) : BW'(b);
            neg1_reg <= a[UW-1] ^ b[BW-1];
            plo_reg  <= (AW+LO)'(ua_reg) * (AW+LO)'(ub_reg[LO-1:0]);
            phi_reg  <= (AW+HI)'(ua_reg) * (AW+HI)'(ub_reg[BW-1:LO]);
            neg2_reg <= neg1_reg;
            p_reg    <= neg2_reg ? -signed'((BW+1)'(mag)) : signed'((BW+1)'(mag));
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== rtl/qvr_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_rotate
// Rotation by a unit quaternion: t = 2 (u x v), r = v + w t + u x t, then
// saturation to the output width.
// ----------------------------------------------------------------------------
module qvr_rotate #(
    parameter int DW = qvr_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic signed [qvr_pkg::UW-1:0] unit [4],
    input  logic signed [DW-1:0]          vec [3],
    input  qvr_pkg::qvr_ctrl_t            ctrl_in,
    output logic signed [DW-1:0]          rot [3],
    output logic                          clip,
    output qvr_pkg::qvr_ctrl_t            ctrl_out
);
    import qvr_pkg::*;

    localparam int TW = DW + 3;
    localparam int RW = DW + 6;

    logic signed [DW:0]   p1 [L1_N];
    logic signed [TW:0]   p2 [L2_N];
    logic signed [UW-1:0] u_d_reg [MUL_LAT][4];
    logic signed [DW-1:0] v_d_reg [MUL_LAT][3];
    qvr_ctrl_t            c_d_reg [MUL_LAT];
    logic signed [TW-1:0] t_next [3];
    logic signed [TW-1:0] t_reg  [3];
    logic signed [UW-1:0] u_t_reg [4];
    logic signed [DW-1:0] v_t_reg [3];
    qvr_ctrl_t            c_t_reg;
    logic signed [DW-1:0] v_e_reg [MUL_LAT][3];
    qvr_ctrl_t            c_e_reg [MUL_LAT];
    logic signed [RW-1:0] r_reg [3];
    qvr_ctrl_t            c_r_reg;
    logic signed [DW-1:0] rot_reg [3];
    logic                 clip_reg;
    qvr_ctrl_t            c_s_reg;
    logic                 fit [3];

    // product layers: u x v terms, then w t and u x t terms
    genvar g;
    generate
        for (g = 0; g < L1_N; g++)
        begin : g_l1
            qvr_mul #(.BW(DW)) u_mul (
                .clk (clk),
                .en  (en),
                .a   (unit[L1_U[g]]),
                .b   (vec[L1_V[g]]),
                .p   (p1[g])
            );
        end
        for (g = 0; g < L2_N; g++)
        begin : g_l2
            qvr_mul #(.BW(TW)) u_mul (
                .clk (clk),
                .en  (en),
                .a   (u_t_reg[L2_U[g]]),
                .b   (t_reg[L2_T[g]]),
                .p   (p2[g])
            );
        end
    endgenerate

    // form t = 2 (u x v)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_next[i] = (TW'(p1[2*i]) - TW'(p1[2*i+1])) <<< 1;
        end
    end

    // hold control beside the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MUL_LAT; s++)
            begin
                c_d_reg[s] <= '0;
                c_e_reg[s] <= '0;
            end
            c_t_reg <= '0;
            c_r_reg <= '0;
            c_s_reg <= '0;
        end
        else if (en)
        begin
            c_d_reg[0] <= ctrl_in;
            c_e_reg[0] <= c_t_reg;
            for (int s = 1; s < MUL_LAT; s++)
            begin
                c_d_reg[s] <= c_d_reg[s-1];
                c_e_reg[s] <= c_e_reg[s-1];
            end
            c_t_reg <= c_d_reg[MUL_LAT-1];
            c_r_reg <= c_e_reg[MUL_LAT-1];
            c_s_reg <= c_r_reg;
        end
    end

    // check that each sum fits the output width
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fit[i] = (r_reg[i][RW-1:DW-1] == '0) || (r_reg[i][RW-1:DW-1] == '1);
        end
    end

    // delay operands, sum, saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_d_reg[0] <= unit;
            v_d_reg[0] <= vec;
            v_e_reg[0] <= v_t_reg;
            for (int s = 1; s < MUL_LAT; s++)
            begin
                u_d_reg[s] <= u_d_reg[s-1];
                v_d_reg[s] <= v_d_reg[s-1];
                v_e_reg[s] <= v_e_reg[s-1];
            end
            t_reg   <= t_next;
            u_t_reg <= u_d_reg[MUL_LAT-1];
            v_t_reg <= v_d_reg[MUL_LAT-1];
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= RW'(v_e_reg[MUL_LAT-1][i]) + RW'(p2[3*i]) +
                            (RW'(p2[3*i+1]) - RW'(p2[3*i+2]));
                if (fit[i])
                begin
                    rot_reg[i] <= r_reg[i][DW-1:0];
                end
                else
                begin
                    rot_reg[i] <= {r_reg[i][RW-1], {(DW-1){~r_reg[i][RW-1]}}};
                end
            end
            clip_reg <= !(fit[0] && fit[1] && fit[2]);
        end
    end

    assign rot      = rot_reg;
    assign clip     = clip_reg;
    assign ctrl_out = c_s_reg;

endmodule
`default_nettype wire

// ===== rtl/qvr_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_out_fifo
// Two-entry result buffer that parts the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module qvr_out_fifo #(
    parameter int W = 3 * qvr_pkg::DATA_WIDTH_DEF + 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    // track fill level
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // store item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ===== rtl/quaternion_vector_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Normalizes a quaternion and rotates a 3-vector by it, saturating results.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+----------
//  sample   | in  | quat_x quat_y quat_z quat_w vec_x vec_y vec_z  | valid/ready
//  result   | out | rot_x rot_y rot_z identity_used clipped        | valid/ready
//
//  One item per cycle sustained while the output buffer has a free entry;
//  the square root has 32 stages and the dividers have 31 stages.
//  Reset clears all valid bits and the two-entry output buffer at once.
//  The pipeline advances whenever the output buffer has a free entry, so an
//  item is accepted while one finished result waits; a stall holds every stage.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
    parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    qvr_sample_if.sink  sample,
    qvr_result_if.source result
);
    import qvr_pkg::*;

    localparam int FW = 3 * DATA_WIDTH + 2;

    logic                         en;
    logic                         full;
    logic signed [DATA_WIDTH-1:0] quat [4];
    logic signed [DATA_WIDTH-1:0] vec [3];
    logic signed [UW-1:0]         unit [4];
    logic signed [DATA_WIDTH-1:0] vec_n [3];
    qvr_ctrl_t                    ctrl_n;
    logic signed [DATA_WIDTH-1:0] rot [3];
    logic                         clip;
    qvr_ctrl_t                    ctrl_r;
    logic [FW-1:0]                out_data;

    // advance while the output buffer has room
    assign en           = !full;
    assign sample.ready = en;

    assign quat[0] = sample.quat_x;
    assign quat[1] = sample.quat_y;
    assign quat[2] = sample.quat_z;
    assign quat[3] = sample.quat_w;
    assign vec[0]  = sample.vec_x;
    assign vec[1]  = sample.vec_y;
    assign vec[2]  = sample.vec_z;

    qvr_norm #(.DW(DATA_WIDTH)) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sample.valid),
        .quat     (quat),
        .vec      (vec),
        .unit     (unit),
        .vec_out  (vec_n),
        .ctrl     (ctrl_n)
    );

    qvr_rotate #(.DW(DATA_WIDTH)) u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .unit     (unit),
        .vec      (vec_n),
        .ctrl_in  (ctrl_n),
        .rot      (rot),
        .clip     (clip),
        .ctrl_out (ctrl_r)
    );

    qvr_out_fifo #(.W(FW)) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (en && ctrl_r.valid),
        .push_data ({rot[2], rot[1], rot[0], ctrl_r.ident, clip}),
        .pop       (result.valid && result.ready),
        .full      (full),
        .out_valid (result.valid),
        .out_data  (out_data)
    );

    assign result.clipped       = out_data[0];
    assign result.identity_used = out_data[1];
    assign result.rot_x         = out_data[2 +: DATA_WIDTH];
    assign result.rot_y         = out_data[2 + DATA_WIDTH +: DATA_WIDTH];
    assign result.rot_z         = out_data[2 + 2 * DATA_WIDTH +: DATA_WIDTH];

endmodule
`default_nettype wire

// ===== rtl/qvr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks of the quaternion vector rotator, bound to the top level.
// ----------------------------------------------------------------------------
module qvr_checker #(
    parameter int DW = qvr_pkg::DATA_WIDTH_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire logic [DW-1:0] rot_x,
    input wire logic [DW-1:0] rot_y,
    input wire logic [DW-1:0] rot_z,
    input wire logic          identity_used,
    input wire logic          clipped
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rot_x) && $stable(rot_y) &&
                                    $stable(rot_z) && $stable(identity_used) &&
                                    $stable(clipped))
        else $error("stalled result changed");

    // input back-pressure only when results wait at the output
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // identity rotation passes the vector through and never clips
    a_ident_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && identity_used |-> !clipped)
        else $error("identity item reported clipping");

endmodule

bind quaternion_vector_rotate qvr_checker #(.DW(DATA_WIDTH)) u_qvr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .rot_x         (result.rot_x),
    .rot_y         (result.rot_y),
    .rot_z         (result.rot_z),
    .identity_used (result.identity_used),
    .clipped       (result.clipped)
);
`default_nettype wire
